### hw/rtl/hrsd_pkg.sv
`default_nettype none
package hrsd_pkg;

   // Ring geometry: slot_position and assigned_slot are 4 bits wide, so the ring is fixed
   localparam int RING_SLOTS = 16;
   localparam int SLOT_W     = 4;
   localparam int PORT_W     = 16;
   localparam int HASH_W     = 32;

   typedef enum logic [1:0] {
      ACT_REGISTER   = 2'd0,
      ACT_UNREGISTER = 2'd1,
      ACT_QUERY      = 2'd2,
      ACT_RESERVED   = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // Outcome of one ring search
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } search_type;

endpackage
`default_nettype wire

### hw/rtl/hash_ring_slot_directory.sv
`default_nettype none
// A request is searched and its port store entry read as it is taken from req_, and the result
// is loaded into the output register once that register is free; the next request waits until then.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, active high; clears the used marks and the handshake state.
// The port store is not swept: only entries marked used are ever read, and those were written.
module hash_ring_slot_directory
   import hrsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] server_port, [19:16] slot_position, [51:20] key_hash, [55:52] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] assigned_slot, [4] slot_assigned, [20:5] found_port, [21] port_found, [23:22] zero
   output logic [23:0]      rsp_tdata
);

   state_type state_ff, state_in;

   logic [RING_SLOTS-1:0] marks_ff, marks_in;
   logic [PORT_W-1:0]     port_mem [RING_SLOTS];
   logic [PORT_W-1:0]     rd_data_ff;

   logic                  pend_hit_ff, pend_hit_in;
   logic                  pend_assigned_ff, pend_assigned_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;

   action_type            action;
   logic [PORT_W-1:0]     server_port;
   logic [SLOT_W-1:0]     slot_position;
   logic [HASH_W-1:0]     key_hash;

   logic                  req_xfer;
   logic                  out_free;
   logic [SLOT_W-1:0]     free_slot;
   logic                  ring_full;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [PORT_W-1:0]     wr_data;
   logic                  search_en;
   logic [SLOT_W-1:0]     search_start;
   logic                  search_with_start;
   search_type            search;

   // Unpack the request
   assign action        = action_type'(req_tuser);
   assign server_port   = req_tdata[15:0];
   assign slot_position = req_tdata[19:16];
   assign key_hash      = req_tdata[51:20];

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Find the lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = RING_SLOTS - 1; i >= 0; i--) begin
         if (!marks_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
      ring_full = &marks_ff;
   end

   // Decode the action: mark update, port store write and search setup
   always_comb begin
      marks_in          = marks_ff;
      wr_en             = 1'b0;
      wr_addr           = '0;
      wr_data           = '0;
      search_en         = 1'b0;
      search_start      = '0;
      search_with_start = 1'b0;
      pend_assigned_in  = pend_assigned_ff;
      pend_slot_in      = pend_slot_ff;
      if (req_xfer) begin
         pend_assigned_in = 1'b0;
         pend_slot_in     = '0;
         unique case (action)
            ACT_REGISTER: begin
               if (!ring_full) begin
                  marks_in[free_slot] = 1'b1;
                  wr_en               = 1'b1;
                  wr_addr             = free_slot;
                  wr_data             = server_port;
                  search_en           = 1'b1;
                  search_start        = free_slot;
                  pend_assigned_in    = 1'b1;
                  pend_slot_in        = free_slot;
               end
            end
            ACT_UNREGISTER: begin
               marks_in[slot_position] = 1'b0;
               wr_en                   = 1'b1;
               wr_addr                 = slot_position;
               search_en               = 1'b1;
               search_start            = slot_position;
            end
            ACT_QUERY: begin
               search_en         = 1'b1;
               search_start      = key_hash[SLOT_W-1:0];
               search_with_start = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Search the marks as they stand after this item's update
   hrsd_ring_search u_search (
      .used_marks (marks_in),
      .start_slot (search_start),
      .with_start (search_with_start),
      .result     (search)
   );

   assign pend_hit_in = req_xfer ? (search_en && search.hit) : pend_hit_ff;

   // Port store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         port_mem[wr_addr] <= wr_data;
      end
      if (req_xfer) begin
         rd_data_ff <= port_mem[search.slot];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_READ;
         ST_READ: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and result register load
   always_comb begin
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, pend_hit_ff,
                               pend_hit_ff ? rd_data_ff : {PORT_W{1'b0}},
                               pend_assigned_ff, pend_slot_ff};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_hit_ff      <= pend_hit_in;
      pend_assigned_ff <= pend_assigned_in;
      pend_slot_ff     <= pend_slot_in;
      rsp_data_ff      <= rsp_data_in;
   end

endmodule
`default_nettype wire

### hw/rtl/hrsd_ring_search.sv
`default_nettype none
module hrsd_ring_search
   import hrsd_pkg::*;
(
   input  wire logic [RING_SLOTS-1:0] used_marks,
   input  wire logic [SLOT_W-1:0]     start_slot,
   input  wire logic                  with_start,
   output search_type                 result
);

   logic [2*RING_SLOTS-1:0] doubled;
   logic [RING_SLOTS-1:0]   rotated;
   logic [SLOT_W-1:0]       offset;
   logic                    hit;

   // Rotate the marks so that the start slot sits at bit zero
   always_comb begin
      doubled = {used_marks, used_marks} >> start_slot;
      rotated = doubled[RING_SLOTS-1:0];
      if (!with_start) begin
         rotated[0] = 1'b0;
      end
   end

   // Pick the nearest used slot going round the ring
   always_comb begin
      hit    = 1'b0;
      offset = '0;
      for (int i = RING_SLOTS - 1; i >= 0; i--) begin
         if (rotated[i]) begin
            hit    = 1'b1;
            offset = SLOT_W'(i);
         end
      end
   end

   assign result.hit  = hit;
   assign result.slot = start_slot + offset;

endmodule
`default_nettype wire

### tb/hash_ring_slot_directory_tb.sv
`default_nettype none
module hash_ring_slot_directory_tb;
   import hrsd_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int ITEMS_PER_LEG  = 350;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int NO_SLOT        = -1;
   localparam int DIRECTED_ROWS  = 25;

   // One result, laid out as rsp_tdata[21:0]
   typedef struct packed {
      logic        port_found;
      logic [15:0] found_port;
      logic        slot_assigned;
      logic [3:0]  assigned_slot;
   } lookup_rsp_type;

   // One directed row; when pinned is set the want_* fields are the expected result
   typedef struct packed {
      action_type  act;
      logic [15:0] port;
      logic [3:0]  pos;
      logic [31:0] hash;
      logic        pinned;
      logic [3:0]  want_slot;
      logic        want_assigned;
      logic [15:0] want_port;
      logic        want_found;
   } directed_row_type;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty ring: query and freeing a free slot find nothing
      '{ACT_QUERY,      16'h0000, 4'h0, 32'h0000_0000, 1'b1, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_UNREGISTER, 16'h0000, 4'hF, 32'h0000_0000, 1'b1, 4'h0, 1'b0, 16'h0000, 1'b0},
      // lone server, then a second server with port zero
      '{ACT_REGISTER,   16'hFFFF, 4'h0, 32'h0000_0000, 1'b1, 4'h0, 1'b1, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h0000, 4'hF, 32'hFFFF_FFFF, 1'b1, 4'h1, 1'b1, 16'hFFFF, 1'b1},
      '{ACT_QUERY,      16'hFFFF, 4'hF, 32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_QUERY,      16'h0000, 4'h0, 32'h0000_0001, 1'b1, 4'h0, 1'b0, 16'h0000, 1'b1},
      '{ACT_RESERVED,   16'hFFFF, 4'hF, 32'hFFFF_FFFF, 1'b1, 4'h0, 1'b0, 16'h0000, 1'b0},
      // fill the rest of the ring
      '{ACT_REGISTER,   16'h0001, 4'hF, 32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h8000, 4'h0, 32'h0000_0000, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h5555, 4'hA, 32'h5555_5555, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'hAAAA, 4'h5, 32'hAAAA_AAAA, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h1234, 4'h3, 32'h1234_5678, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'hFFFE, 4'hC, 32'h8000_0000, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h00FF, 4'h7, 32'h0000_FFFF, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'hFF00, 4'h8, 32'hFFFF_0000, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h0F0F, 4'h1, 32'h0F0F_0F0F, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'hF0F0, 4'hE, 32'hF0F0_F0F0, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h7FFF, 4'h2, 32'h7FFF_FFFF, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h0101, 4'h9, 32'h0101_0101, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'hC3C3, 4'h6, 32'hC3C3_C3C3, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_REGISTER,   16'h3C3C, 4'hB, 32'h3C3C_3C3C, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      // full ring rejects a register
      '{ACT_REGISTER,   16'hBEEF, 4'h4, 32'hDEAD_BEEF, 1'b1, 4'h0, 1'b0, 16'h0000, 1'b0},
      // free the ends of the ring and search across the wrap
      '{ACT_UNREGISTER, 16'hFFFF, 4'h0, 32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_QUERY,      16'h0000, 4'h0, 32'h0000_0010, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0},
      '{ACT_UNREGISTER, 16'h0000, 4'hF, 32'h0000_0000, 1'b0, 4'h0, 1'b0, 16'h0000, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] server_port, [19:16] slot_position, [51:20] key_hash, [55:52] zero
   logic [55:0] req_tdata = '0;
   // [1:0] action
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] assigned_slot, [4] slot_assigned, [20:5] found_port, [21] port_found, [23:22] zero
   logic [23:0] rsp_tdata;

   // Shadow copy of the ring
   logic [15:0] slot_ports [RING_SLOTS];
   bit          slot_used  [RING_SLOTS];

   lookup_rsp_type expected_rsp_q [$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          rsp_hold_req = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          action_count [4] = '{0, 0, 0, 0};
   int          full_rejects = 0;
   int          empty_searches = 0;

   hash_ring_slot_directory DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Walk the ring from start for the first used slot
   function automatic bit ring_next(int start, bit with_start, output logic [15:0] port);
      int idx;
      for (int k = with_start ? 0 : 1; k < RING_SLOTS; k++) begin
         idx = (start + k) % RING_SLOTS;
         if (slot_used[idx]) begin
            port = slot_ports[idx];
            return 1'b1;
         end
      end
      port = '0;
      empty_searches++;
      return 1'b0;
   endfunction

   // Apply one request to the shadow ring and return its result
   function automatic lookup_rsp_type directory_apply(action_type act, logic [15:0] port,
                                                      logic [3:0] pos, logic [31:0] hash);
      lookup_rsp_type rsp;
      logic [15:0] next_port;
      int          free_slot;
      rsp = '0;
      next_port = '0;
      case (act)
         ACT_REGISTER: begin
            free_slot = NO_SLOT;
            for (int i = RING_SLOTS - 1; i >= 0; i--)
               if (!slot_used[i]) free_slot = i;
            if (free_slot == NO_SLOT) begin
               full_rejects++;
            end else begin
               slot_used[free_slot]  = 1'b1;
               slot_ports[free_slot] = port;
               rsp.assigned_slot     = free_slot[3:0];
               rsp.slot_assigned     = 1'b1;
               rsp.port_found        = ring_next(free_slot, 1'b0, next_port);
               rsp.found_port        = next_port;
            end
         end
         ACT_UNREGISTER: begin
            // slot_position is 4 bits, so it is always on the ring
            slot_used[pos]  = 1'b0;
            slot_ports[pos] = '0;
            rsp.port_found  = ring_next(int'(pos), 1'b0, next_port);
            rsp.found_port  = next_port;
         end
         ACT_QUERY: begin
            rsp.port_found = ring_next(int'(hash % RING_SLOTS), 1'b1, next_port);
            rsp.found_port = next_port;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Offer one request, hold it until the transfer, then record its expected result
   task automatic push_request(action_type act, logic [15:0] port, logic [3:0] pos,
                               logic [31:0] hash, bit pinned, lookup_rsp_type pinned_rsp);
      lookup_rsp_type model_rsp;
      bit          taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'h0, hash, pos, port};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      model_rsp = directory_apply(act, port, pos, hash);
      expected_rsp_q.push_back(pinned ? pinned_rsp : model_rsp);
      action_count[act]++;
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Drive rsp_tready: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (rsp_hold_req) begin
         hold_left    = LONG_HOLD;
         rsp_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result transfer against the oldest expectation
   always @(negedge clock) begin : rsp_monitor
      lookup_rsp_type got;
      lookup_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[21:0];
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("assigned_slot", want.assigned_slot, got.assigned_slot);
            check_field("slot_assigned", want.slot_assigned, got.slot_assigned);
            check_field("found_port", want.found_port, got.found_port);
            check_field("port_found", want.port_found, got.port_found);
            check_field("pad", 0, rsp_tdata[23:22]);
         end
      end
   end

   // Bound the run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               expected_rsp_q.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      lookup_rsp_type pinned_rsp;
      action_type  act;
      logic [15:0] port;
      logic [3:0]  pos;
      logic [31:0] hash;
      int          pick;
      int          occupancy;
      int          used_list [$];
      bit          filling;

      for (int i = 0; i < RING_SLOTS; i++) begin
         slot_ports[i] = '0;
         slot_used[i]  = 1'b0;
      end

      // Hold reset, then release it for good
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the first idling mix
      send_idle_pct = 8;
      recv_idle_pct = 61;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         pinned_rsp.assigned_slot = DIRECTED[r].want_slot;
         pinned_rsp.slot_assigned = DIRECTED[r].want_assigned;
         pinned_rsp.found_port    = DIRECTED[r].want_port;
         pinned_rsp.port_found    = DIRECTED[r].want_found;
         push_request(DIRECTED[r].act, DIRECTED[r].port, DIRECTED[r].pos, DIRECTED[r].hash,
                      DIRECTED[r].pinned, pinned_rsp);
      end
      wait_drained();

      // Random traffic in three idling legs; the ring swings between full and empty
      filling = 1'b1;
      pinned_rsp = '0;
      for (int leg = 0; leg < 3; leg++) begin
         send_idle_pct = (leg == 0) ? 8 : (leg == 1) ? 61 : 0;
         recv_idle_pct = (leg == 0) ? 61 : (leg == 1) ? 8 : 0;
         for (int n = 0; n < ITEMS_PER_LEG; n++) begin
            // back up the output while requests keep coming
            if (leg == 2 && n == 100) rsp_hold_req = 1'b1;

            occupancy = 0;
            used_list.delete();
            for (int i = 0; i < RING_SLOTS; i++)
               if (slot_used[i]) begin
                  occupancy++;
                  used_list.push_back(i);
               end
            if (filling && occupancy == RING_SLOTS && $urandom_range(3) == 0) filling = 1'b0;
            if (!filling && occupancy == 0 && $urandom_range(3) == 0) filling = 1'b1;

            pick = $urandom_range(99);
            if (pick < (filling ? 55 : 15))      act = ACT_REGISTER;
            else if (pick < (filling ? 70 : 65)) act = ACT_UNREGISTER;
            else if (pick < 96)                  act = ACT_QUERY;
            else                                 act = ACT_RESERVED;

            case ($urandom_range(9))
               0:       port = 16'h0000;
               1:       port = 16'hFFFF;
               default: port = 16'($urandom());
            endcase
            hash = $urandom();
            pos  = 4'($urandom_range(RING_SLOTS - 1));
            // mostly free a slot that is in use
            if (act == ACT_UNREGISTER && used_list.size() != 0 && $urandom_range(3) != 0)
               pos = 4'(used_list[$urandom_range(used_list.size() - 1)]);

            push_request(act, port, pos, hash, 1'b0, pinned_rsp);
         end
         wait_drained();
      end

      // Let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d register, %0d unregister, %0d query and %0d reserved transfers",
               action_count[ACT_REGISTER], action_count[ACT_UNREGISTER],
               action_count[ACT_QUERY], action_count[ACT_RESERVED]);
      $display("Full-ring rejects: %0d, searches with no server: %0d, cycles: %0d",
               full_rejects, empty_searches, cycle_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
